>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, off while reset is low.
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

>>> src/rbpc_pkg.sv
package rbpc_pkg;

    localparam int PIXEL_W  = 8;
    localparam int ROWS_W   = 64;
    localparam int BAND_W   = 2;
    localparam int GROUP_W  = 4;
    localparam int STORE_W  = 56;
    localparam logic [2:0] LAST_ROW = 3'd7;

    // One completed 8x8 block on its way to the transpose stage.
    typedef struct packed {
        logic [ROWS_W-1:0]  rows;
        logic [BAND_W-1:0]  band;
        logic [GROUP_W-1:0] group;
        logic               last;
    } block_t;

endpackage

>>> src/row_bitmap_to_page_columns_unit.sv
// Turns a one-bit-per-pixel frame, streamed as row-major bytes (BYTES_PER_ROW bytes per
// row, MSB leftmost, 8*BANDS rows), into 8x8 blocks of column-major page bytes. Rows 0
// to 6 of each band are held per column group; every byte of row 7 completes a block,
// which leaves as one 64-bit word whose byte i is column 8g+i with bit k from row k.
// Bytes of rows 0 to 6 produce no output word. tuser on the input marks the first byte
// of a frame and resets the position; tlast on the output marks the last block of the
// frame. One byte is taken every cycle while the queue is not full; a block word goes
// from its row-7 byte into the queue, then into the transpose register, and the two-entry
// queue between the input side and the output register absorbs output stalls.
module row_bitmap_to_page_columns_unit #(
    parameter int BYTES_PER_ROW = 16,
    parameter int BANDS         = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel_byte
    input  logic [0:0]  s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] column_bytes
    output logic [5:0]  m_tuser,   // [1:0] band_index, [5:2] column_group
    output logic        m_tlast    // frame_last
);
    import rbpc_pkg::*;

    logic   accept;
    logic   push;
    logic   pop;
    logic   empty;
    logic   full;
    block_t push_block;
    block_t head;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    rbpc_front #(
        .BYTES_PER_ROW (BYTES_PER_ROW),
        .BANDS         (BANDS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pixel_byte  (s_tdata),
        .frame_start (s_tuser[0]),
        .push        (push),
        .push_block  (push_block)
    );

    rbpc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_block (push_block),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    rbpc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> src/rbpc_front.sv
module rbpc_front #(
    parameter int BYTES_PER_ROW = 16,
    parameter int BANDS         = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [rbpc_pkg::PIXEL_W-1:0] pixel_byte,
    input  logic                        frame_start,
    output logic                        push,
    output rbpc_pkg::block_t            push_block
);
    import rbpc_pkg::*;

    localparam int GW = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
    localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam logic [GW-1:0] LAST_GROUP = GW'(BYTES_PER_ROW - 1);
    localparam logic [BW-1:0] LAST_BAND  = BW'(BANDS - 1);

    logic [2:0]    row_reg, row_next, row_cur;
    logic [GW-1:0] group_reg, group_next, group_cur;
    logic [BW-1:0] band_reg, band_next, band_cur;

    // Rows 0 to 6 of the current band, one entry per column group.
    logic [STORE_W-1:0] band_rows_mem [BYTES_PER_ROW];

    always_comb
    begin
        row_cur   = frame_start ? 3'd0 : row_reg;
        group_cur = frame_start ? '0 : group_reg;
        band_cur  = frame_start ? '0 : band_reg;

        row_next   = row_cur;
        band_next  = band_cur;
        group_next = group_cur + GW'(1);
        if (group_cur == LAST_GROUP)
        begin
            group_next = '0;
            row_next   = row_cur + 3'd1;
            if (row_cur == LAST_ROW)
            begin
                band_next = (band_cur == LAST_BAND) ? '0 : band_cur + BW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= 3'd0;
            group_reg <= '0;
            band_reg  <= '0;
        end
        else if (accept)
        begin
            row_reg   <= row_next;
            group_reg <= group_next;
            band_reg  <= band_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && row_cur != LAST_ROW)
        begin
            band_rows_mem[group_cur][{row_cur, 3'b000} +: PIXEL_W] <= pixel_byte;
        end
    end

    assign push             = accept && (row_cur == LAST_ROW);
    assign push_block.rows  = {pixel_byte, band_rows_mem[group_cur]};
    assign push_block.band  = BAND_W'(band_cur);
    assign push_block.group = GROUP_W'(group_cur);
    assign push_block.last  = (band_cur == LAST_BAND) && (group_cur == LAST_GROUP);

endmodule

>>> src/rbpc_queue.sv
`include "assert_macros.svh"

module rbpc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rbpc_pkg::block_t push_block,
    input  logic             pop,
    output rbpc_pkg::block_t head,
    output logic             empty,
    output logic             full
);
    import rbpc_pkg::*;

    block_t     slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_block;
        end
    end

    `ASSERT_NEVER(a_no_overflow, clk, rst_n, push && full, "block pushed into a full queue")
    `ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && empty, "block popped from an empty queue")
    `ASSERT_CLK(a_count_ptrs, clk, rst_n, (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg), "queue pointers disagree with count")
    `ASSERT_NEVER(a_count_range, clk, rst_n, count_reg == 2'd3, "queue count out of range")

endmodule

>>> src/rbpc_back.sv
module rbpc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rbpc_pkg::block_t              head,
    input  logic                          empty,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rbpc_pkg::ROWS_W-1:0]   m_tdata,
    output logic [rbpc_pkg::BAND_W+rbpc_pkg::GROUP_W-1:0] m_tuser,
    output logic                          m_tlast
);
    import rbpc_pkg::*;

    // Column byte i takes bit 7-i of every row byte; row k lands in bit k.
    function automatic logic [ROWS_W-1:0] transpose_block(input logic [ROWS_W-1:0] rows);
        logic [ROWS_W-1:0] cols;
        cols = '0;
        for (int i = 0; i < 8; i++)
        begin
            for (int k = 0; k < 8; k++)
            begin
                cols[8*i + k] = rows[8*k + 7 - i];
            end
        end
        return cols;
    endfunction

    logic                      valid_reg;
    logic [ROWS_W-1:0]         data_reg;
    logic [BAND_W+GROUP_W-1:0] user_reg;
    logic                      last_reg;

    assign pop = !empty && (!valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || m_tready)
        begin
            valid_reg <= !empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= transpose_block(head.rows);
            user_reg <= {head.group, head.band};
            last_reg <= head.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule
